[src/srtf_pkg.sv]
package srtf_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic KIND_ARRIVE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  job_id;
		logic [15:0] job_burst;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  done_id;
		logic [31:0] arrived_at;
		logic [15:0] burst_length;
		logic [31:0] waiting_time;
		logic [31:0] turnaround_time;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  job;
		logic [31:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
	} entry_t;

	typedef struct packed {
		logic take_item;
		logic find_step;
		logic scan_issue;
		logic tick_done;
		logic fetch;
		logic update;
		logic load_reject;
		logic report;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic burst_zero;
		logic full;
		logic slot_free;
		logic scan_last;
		logic found;
		logic rem_last;
		logic out_free;
	} stat_t;

endpackage

[src/srtf_ram.sv]
module srtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/srtf_ctrl.sv]
module srtf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  srtf_pkg::stat_t stat,
	output srtf_pkg::cmd_t  cmd
);
	import srtf_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DISPATCH = 8'b0000_0010,
		S_FIND     = 8'b0000_0100,
		S_SCAN     = 8'b0000_1000,
		S_DRAIN    = 8'b0001_0000,
		S_FETCH    = 8'b0010_0000,
		S_UPDATE   = 8'b0100_0000,
		S_REPORT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.take_item = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_tick) begin
					state_d = S_SCAN;
				end else if (stat.burst_zero || stat.full) begin
					cmd.load_reject = 1'b1;
					state_d         = S_REPORT;
				end else begin
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				cmd.find_step = 1'b1;
				if (stat.slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.tick_done = 1'b1;
				state_d       = S_FETCH;
			end
			S_FETCH: begin
				if (stat.found) begin
					cmd.fetch = 1'b1;
					state_d   = S_UPDATE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = stat.rem_last ? S_REPORT : S_IDLE;
			end
			S_REPORT: begin
				if (stat.out_free) begin
					cmd.report = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A result is only reported after a completion or a rejected arrival.
	a_report_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REPORT |-> $past(state_q) == S_REPORT
			|| $past(state_q) == S_UPDATE || $past(state_q) == S_DISPATCH)
		else $error("report entered from wrong state");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> state_q == S_FETCH)
		else $error("drain did not move to fetch");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

endmodule

[src/srtf_dp.sv]
module srtf_dp #(
	parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  srtf_pkg::req_t  req,
	input  srtf_pkg::cmd_t  cmd,
	output srtf_pkg::stat_t stat,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output srtf_pkg::rsp_t  rsp
);
	import srtf_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = $bits(entry_t);

	req_t               item_q;
	logic [SLOTS-1:0]   valid_q;
	logic [CW-1:0]      count_q;
	logic [31:0]        time_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      idx_s1;
	logic               pend_s1;
	logic               found_q;
	logic [15:0]        best_rem_q;
	logic [IW-1:0]      best_idx_q;
	rsp_t               res_q;
	rsp_t               out_q;
	logic               out_valid_q;

	entry_t             rd_entry;
	logic [EW-1:0]      rd_bits;
	logic               we;
	logic [IW-1:0]      waddr;
	entry_t             wentry;
	logic [IW-1:0]      raddr;
	logic               better;

	assign rd_entry = entry_t'(rd_bits);
	assign raddr    = cmd.fetch ? best_idx_q : idx_q;
	assign better   = !found_q || (rd_entry.remaining < best_rem_q);

	always_comb begin
		we     = 1'b0;
		waddr  = idx_q;
		wentry = '{job: item_q.job_id, arrival: time_q, burst: item_q.job_burst,
			remaining: item_q.job_burst};
		if (cmd.find_step && !valid_q[idx_q]) begin
			we = 1'b1;
		end else if (cmd.update && !stat.rem_last) begin
			we               = 1'b1;
			waddr            = best_idx_q;
			wentry           = rd_entry;
			wentry.remaining = rd_entry.remaining - 16'd1;
		end
	end

	srtf_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (EW'(wentry)),
		.raddr (raddr),
		.rdata (rd_bits)
	);

	always_comb begin
		stat.is_tick    = item_q.kind == KIND_TICK;
		stat.burst_zero = item_q.job_burst == 16'd0;
		stat.full       = count_q == CW'(SLOTS);
		stat.slot_free  = !valid_q[idx_q];
		stat.scan_last  = idx_q == IW'(SLOTS - 1);
		stat.found      = found_q;
		stat.rem_last   = rd_entry.remaining == 16'd1;
		stat.out_free   = !out_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			count_q     <= '0;
			time_q      <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			if (cmd.take_item) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.find_step) begin
				if (!valid_q[idx_q]) begin
					valid_q[idx_q] <= 1'b1;
					count_q        <= count_q + CW'(1);
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (cmd.scan_issue) begin
				pend_s1 <= valid_q[idx_q];
				if (!stat.scan_last) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			// fold the slot read last cycle into the running minimum
			if (pend_s1 && better) begin
				found_q <= 1'b1;
			end
			if (cmd.tick_done) begin
				time_q <= time_q + 32'd1;
			end
			if (cmd.update && stat.rem_last) begin
				valid_q[best_idx_q] <= 1'b0;
				count_q             <= count_q - CW'(1);
			end
			if (cmd.report) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_q <= req;
		end
		idx_s1 <= idx_q;
		if (pend_s1 && better) begin
			best_rem_q <= rd_entry.remaining;
			best_idx_q <= idx_s1;
		end
		if (cmd.load_reject) begin
			res_q.status          <= stat.burst_zero ? ST_ZERO : ST_FULL;
			res_q.done_id         <= item_q.job_id;
			res_q.arrived_at      <= time_q;
			res_q.burst_length    <= item_q.job_burst;
			res_q.waiting_time    <= '0;
			res_q.turnaround_time <= '0;
		end else if (cmd.update) begin
			res_q.status          <= ST_DONE;
			res_q.done_id         <= rd_entry.job;
			res_q.arrived_at      <= rd_entry.arrival;
			res_q.burst_length    <= rd_entry.burst;
			res_q.waiting_time    <= time_q - rd_entry.arrival - 32'(rd_entry.burst);
			res_q.turnaround_time <= time_q - rd_entry.arrival;
		end
		if (cmd.report) begin
			out_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_q)))
		else $error("occupancy count out of step with valid bits");

	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		time_q != $past(time_q) |-> time_q == $past(time_q) + 32'd1)
		else $error("time moved by more than one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		we && cmd.find_step |-> !valid_q[waddr])
		else $error("arrival written over a live slot");

	a_report_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report |-> !out_valid_q || !rsp_stall)
		else $error("result loaded over a waiting one");

endmodule

[src/shortest_remaining_time_scheduler_core.sv]
// Preemptive shortest-remaining-time-first scheduler.
// req channel (req_valid/req_stall, payload req): kind selects an arrival,
// which stores job_id and job_burst in the lowest free slot stamped with the
// current time, or a tick, which serves one time unit to the live job with
// the least remaining time (lower slot wins ties) and then advances time.
// rsp channel (rsp_valid/rsp_stall, payload rsp): one item per completed job
// and per rejected arrival (table full or zero burst); other items give none.
// One item is in work at a time; req_stall is low only while idle.
// Per item: an accepted arrival probes slots upward from slot 0 until one is
// free; a rejected arrival goes to staging its result on rsp; a tick walks the
// whole slot table, one read of the table memory per cycle, then serves the
// chosen job, if any, and stages a result when that job completes.
// While rsp is stalled a staged result holds in the output register; the
// next item is taken meanwhile, and a further result waits for that register.
// Reset empties the table and clears time to zero; no clearing pass is needed.
module shortest_remaining_time_scheduler_core #(
	parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  srtf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output srtf_pkg::rsp_t rsp
);
	import srtf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	srtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	srtf_dp #(.SLOTS(SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[dv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srtf_pkg::*;

	localparam int SLOTS       = SLOTS_DEF;
	localparam int RAND_ITEMS  = 1000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 60;
	localparam int PHASE_LEN   = 150;

	localparam int PH_CLEAN    = 0;
	localparam int PH_TX_IDLE  = 1;
	localparam int PH_RX_STALL = 2;
	localparam int PH_BOTH     = 3;

	typedef struct {
		req_t req;
		logic wait_drain;
	} job_item_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	job_item_t pend_q[$];
	rsp_t      outcome_q[$];

	// mirror of the job table and the scheduler clock
	logic        tbl_live [SLOTS];
	entry_t      tbl [SLOTS];
	logic [31:0] sched_now;

	int unsigned acc_cnt   = 0;
	int unsigned issued    = 0;
	int unsigned hold_at   = 0;
	int          hold_left = 0;
	logic        hold_used = 1'b0;
	int          err_cnt   = 0;
	int          n_arrive  = 0;
	int          n_tick    = 0;
	int          n_done    = 0;
	int          n_full    = 0;
	int          n_zero    = 0;

	shortest_remaining_time_scheduler_core #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	function automatic int phase_now();
		return (acc_cnt / PHASE_LEN) % 4;
	endfunction

	function automatic int tx_idle_pct();
		case (phase_now())
			PH_CLEAN:   return 0;
			PH_TX_IDLE: return 67;
			PH_BOTH:    return 17;
			default:    return 0;
		endcase
	endfunction

	function automatic int rx_stall_pct();
		case (phase_now())
			PH_CLEAN:    return 0;
			PH_RX_STALL: return 67;
			PH_BOTH:     return 17;
			default:     return 0;
		endcase
	endfunction

	// Serve one arrival or tick against the mirrored table, queue any outcome.
	function automatic void sched_step(input req_t r);
		rsp_t        res;
		int          pick;
		logic        hit;
		logic [31:0] turn;
		res  = '0;
		pick = 0;
		hit  = 1'b0;
		if (r.kind == KIND_ARRIVE) begin
			n_arrive++;
			res.done_id    = r.job_id;
			res.arrived_at = sched_now;
			if (r.job_burst == 16'd0) begin
				res.status = ST_ZERO;
				n_zero++;
				outcome_q.push_back(res);
				return;
			end
			for (int k = 0; k < SLOTS; k++) begin
				if (!tbl_live[k]) begin
					tbl_live[k]      = 1'b1;
					tbl[k].job       = r.job_id;
					tbl[k].arrival   = sched_now;
					tbl[k].burst     = r.job_burst;
					tbl[k].remaining = r.job_burst;
					return;
				end
			end
			res.status       = ST_FULL;
			res.burst_length = r.job_burst;
			n_full++;
			outcome_q.push_back(res);
			return;
		end
		n_tick++;
		for (int k = 0; k < SLOTS; k++) begin
			if (tbl_live[k] && (!hit || tbl[k].remaining < tbl[pick].remaining)) begin
				hit  = 1'b1;
				pick = k;
			end
		end
		sched_now = sched_now + 32'd1;
		if (!hit)
			return;
		tbl[pick].remaining = tbl[pick].remaining - 16'd1;
		if (tbl[pick].remaining != 16'd0)
			return;
		turn                 = sched_now - tbl[pick].arrival;
		tbl_live[pick]       = 1'b0;
		res.status           = ST_DONE;
		res.done_id          = tbl[pick].job;
		res.arrived_at       = tbl[pick].arrival;
		res.burst_length     = tbl[pick].burst;
		res.turnaround_time  = turn;
		res.waiting_time     = turn - 32'(tbl[pick].burst);
		n_done++;
		outcome_q.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
		err_cnt++;
	endtask

	task automatic add_item(input logic kind, input logic [7:0] id, input logic [15:0] burst,
		input logic wait_drain);
		job_item_t it;
		it.req.kind      = kind;
		it.req.job_id    = id;
		it.req.job_burst = burst;
		it.wait_drain    = wait_drain;
		pend_q.push_back(it);
	endtask

	// Check the outgoing result first, then predict the item taken at this edge.
	always @(posedge clk) begin : mon
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("unexpected result, done_id", 32'(rsp.done_id), 32'd0);
			end else begin
				want = outcome_q.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.done_id !== want.done_id)
					report_mismatch("done_id", 32'(rsp.done_id), 32'(want.done_id));
				if (rsp.arrived_at !== want.arrived_at)
					report_mismatch("arrived_at", rsp.arrived_at, want.arrived_at);
				if (rsp.burst_length !== want.burst_length)
					report_mismatch("burst_length", 32'(rsp.burst_length),
						32'(want.burst_length));
				if (rsp.waiting_time !== want.waiting_time)
					report_mismatch("waiting_time", rsp.waiting_time, want.waiting_time);
				if (rsp.turnaround_time !== want.turnaround_time)
					report_mismatch("turnaround_time", rsp.turnaround_time,
						want.turnaround_time);
			end
		end
		if (req_valid && !req_stall) begin
			sched_step(req);
			acc_cnt <= acc_cnt + 1;
		end
	end

	always @(negedge clk) begin : drv
		logic send;
		logic free;
		free = !req_valid || acc_cnt == issued;
		send = 1'b0;
		if (arst_n && free && pend_q.size() != 0) begin
			// hold a drain-marked item until every outstanding result is out
			send = !(pend_q[0].wait_drain && outcome_q.size() != 0) &&
				$urandom_range(0, 99) >= tx_idle_pct();
		end
		if (send) begin
			req       <= pend_q[0].req;
			req_valid <= 1'b1;
			issued    <= issued + 1;
			void'(pend_q.pop_front());
		end else if (free) begin
			req_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin : rcv
		if (!hold_used && hold_at != 0 && acc_cnt >= hold_at) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= $urandom_range(0, 99) < rx_stall_pct();
		end
	end

	initial begin
		int sel;
		logic [15:0] b;
		for (int k = 0; k < SLOTS; k++)
			tbl_live[k] = 1'b0;
		sched_now = '0;

		// tick on an empty table, zero burst, a long job that stays resident
		add_item(KIND_TICK, 8'h00, 16'h0000, 1'b0);
		add_item(KIND_ARRIVE, 8'h00, 16'h0000, 1'b0);
		add_item(KIND_ARRIVE, 8'hFF, 16'hFFFF, 1'b0);
		add_item(KIND_TICK, 8'hFF, 16'hFFFF, 1'b0);
		// equal remaining times: lower slot goes first
		add_item(KIND_ARRIVE, 8'h5A, 16'h0001, 1'b0);
		add_item(KIND_ARRIVE, 8'hA5, 16'h0001, 1'b0);
		add_item(KIND_TICK, 8'h00, 16'h0000, 1'b0);
		add_item(KIND_TICK, 8'h00, 16'h0000, 1'b0);
		// fill the table, then overfill it
		for (int k = 1; k < SLOTS; k++)
			add_item(KIND_ARRIVE, 8'(8'h10 + k), 16'h0002, 1'b0);
		add_item(KIND_ARRIVE, 8'hC3, 16'h8000, 1'b0);
		add_item(KIND_ARRIVE, 8'h3C, 16'h0000, 1'b0);
		add_item(KIND_ARRIVE, 8'h77, 16'h7FFF, 1'b0);

		// receiver holds off while rejections keep coming
		hold_at = pend_q.size();
		for (int k = 0; k < 6; k++)
			add_item(KIND_ARRIVE, 8'(8'hE0 + k), 16'h0000, 1'b0);
		repeat (2 * SLOTS) add_item(KIND_TICK, 8'h00, 16'h0000, 1'b0);

		while (pend_q.size() < RAND_ITEMS + hold_at) begin
			if ($urandom_range(0, 99) < 10) begin
				// flood: fill the table from any state, overfill, then drain
				for (int k = 0; k < SLOTS; k++)
					add_item(KIND_ARRIVE, 8'($urandom_range(0, 255)),
						16'($urandom_range(1, 8)), k == 0);
				repeat (2) add_item(KIND_ARRIVE, 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)), 1'b0);
				repeat (SLOTS * 8 + 2) add_item(KIND_TICK, 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)), 1'b0);
			end else begin
				repeat (20) begin
					if ($urandom_range(0, 99) < 15) begin
						sel = $urandom_range(0, 99);
						if (sel < 4)
							b = 16'd0;
						else if (sel < 88)
							b = 16'($urandom_range(1, 4));
						else
							b = 16'($urandom_range(5, 40));
						add_item(KIND_ARRIVE, 8'($urandom_range(0, 255)), b, 1'b0);
					end else begin
						add_item(KIND_TICK, 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65535)), 1'b0);
					end
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || acc_cnt != issued)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d items: %0d arrivals and %0d ticks", acc_cnt, n_arrive, n_tick);
		$display("outcomes: %0d jobs finished, %0d refused on a full table, %0d zero-burst refusals",
			n_done, n_full, n_zero);
		if (err_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout: %0d of %0d items taken, %0d results outstanding",
			acc_cnt, issued, outcome_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
